// File: rtl/qwls_pkg.sv
package qwls_pkg;

  // Character codes that steer the splitter.
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChSQuote = 8'h27;
  localparam logic [7:0] ChDQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;

  // Parse modes, one-hot.
  typedef enum logic [4:0] {
    MODE_SKIP    = 5'b00001,
    MODE_BARE    = 5'b00010,
    MODE_SQ      = 5'b00100,
    MODE_DQ      = 5'b01000,
    MODE_COMMENT = 5'b10000
  } mode_t;

  // One result transaction as held in the output queue.
  typedef struct packed {
    logic [7:0] out_char;
    logic       has_char;
    logic       word_end;
    logic       line_end;
    logic       bad_line;
    logic       last_of_item;
  } result_t;

  localparam result_t ResultNone = '0;

endpackage

// File: rtl/quoted_word_line_splitter.sv
// Quoted-word line splitter. Feed one character per input transaction and
// close the line with a transaction that has end_of_line set; each input
// yields zero, one or two result transactions (word characters, word-end
// marks, and exactly one line-end result per line), with last_of_item on
// the final result of each input. The parse state is updated in the cycle
// an input is accepted and its results go straight into a four-entry output
// queue, so one input is taken per cycle while the queue holds at most two
// results; results leave at one per cycle while out_ready is high, so the two
// results of a two-result input leave one after the other.
module quoted_word_line_splitter
  import qwls_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  input  logic       end_of_line,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       has_char,
  output logic       word_end,
  output logic       line_end,
  output logic       bad_line,
  output logic       last_of_item
);

  localparam int QDepth = 4;
  localparam int CntW   = $clog2(QDepth + 1);

  mode_t             mode, mode_next;
  logic              esc, esc_next;
  result_t           queue [QDepth];
  result_t           queue_next [QDepth];
  logic [CntW-1:0]   count, count_next;
  logic [CntW-1:0]   base;
  logic [1:0]        n_res;
  result_t           res0, res1;
  logic              accept, pop, blank, is_quote;
  logic [7:0]        quote_ch;

  assign accept   = in_valid && in_ready;
  assign pop      = out_valid && out_ready;
  assign in_ready = (count <= CntW'(QDepth - 2));

  // Decode one input against the parse state.
  always_comb begin
    blank     = (char_code == ChSpace) || (char_code == ChTab);
    quote_ch  = (mode == MODE_SQ) ? ChSQuote : ChDQuote;
    is_quote  = (char_code == quote_ch);
    mode_next = mode;
    esc_next  = esc;
    n_res     = 2'd0;
    res0      = ResultNone;
    res1      = ResultNone;
    if (end_of_line) begin
      n_res         = 2'd1;
      res0.line_end = 1'b1;
      res0.word_end = (mode == MODE_BARE) || (mode == MODE_SQ) || (mode == MODE_DQ);
      res0.bad_line = (mode == MODE_SQ) || (mode == MODE_DQ);
      mode_next     = MODE_SKIP;
      esc_next      = 1'b0;
    end else begin
      unique case (mode)
        MODE_BARE: begin
          n_res = 2'd1;
          if (blank) begin
            res0.word_end = 1'b1;
            mode_next     = MODE_SKIP;
          end else begin
            res0.out_char = char_code;
            res0.has_char = 1'b1;
          end
        end
        MODE_SQ, MODE_DQ: begin
          if (is_quote) begin
            n_res = 2'd1;
            if (esc) begin
              res0.out_char = char_code;
              res0.has_char = 1'b1;
              esc_next      = 1'b0;
            end else begin
              res0.word_end = 1'b1;
              mode_next     = MODE_SKIP;
            end
          end else if (char_code == ChBslash) begin
            esc_next = 1'b1;
          end else if (esc) begin
            n_res         = 2'd2;
            res0.out_char = ChBslash;
            res0.has_char = 1'b1;
            res1.out_char = char_code;
            res1.has_char = 1'b1;
            esc_next      = 1'b0;
          end else begin
            n_res         = 2'd1;
            res0.out_char = char_code;
            res0.has_char = 1'b1;
          end
        end
        MODE_COMMENT: begin
          mode_next = MODE_COMMENT;
        end
        default: begin
          // Between words.
          mode_next = MODE_SKIP;
          if (blank) begin
            mode_next = MODE_SKIP;
          end else if (char_code == ChHash) begin
            mode_next = MODE_COMMENT;
          end else if (char_code == ChSQuote) begin
            mode_next = MODE_SQ;
          end else if (char_code == ChDQuote) begin
            mode_next = MODE_DQ;
          end else begin
            mode_next     = MODE_BARE;
            n_res         = 2'd1;
            res0.out_char = char_code;
            res0.has_char = 1'b1;
          end
        end
      endcase
    end
    res0.last_of_item = (n_res == 2'd1);
    res1.last_of_item = 1'b1;
  end

  // Output queue: head in entry 0, shift on pop, append new results behind.
  always_comb begin
    for (int i = 0; i < QDepth; i++) begin
      if (pop && (i < QDepth - 1)) begin
        queue_next[i] = queue[i+1];
      end else begin
        queue_next[i] = queue[i];
      end
    end
    base = pop ? (count - CntW'(1)) : count;
    if (accept) begin
      for (int i = 0; i < QDepth; i++) begin
        if ((n_res != 2'd0) && (CntW'(i) == base)) begin
          queue_next[i] = res0;
        end
        if ((n_res == 2'd2) && (CntW'(i) == base + CntW'(1))) begin
          queue_next[i] = res1;
        end
      end
    end
    count_next = base + (accept ? CntW'(n_res) : CntW'(0));
  end

  // State and queue registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_SKIP;
      esc   <= 1'b0;
      count <= '0;
    end else begin
      if (accept) begin
        mode <= mode_next;
        esc  <= esc_next;
      end
      count <= count_next;
    end
    for (int i = 0; i < QDepth; i++) begin
      queue[i] <= queue_next[i];
    end
  end

  // Head of the queue drives the result ports.
  assign out_valid    = (count != '0);
  assign out_char     = queue[0].out_char;
  assign has_char     = queue[0].has_char;
  assign word_end     = queue[0].word_end;
  assign line_end     = queue[0].line_end;
  assign bad_line     = queue[0].bad_line;
  assign last_of_item = queue[0].last_of_item;

endmodule

// File: rtl/qwls_checker.sv
module qwls_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       has_char,
  input logic       word_end,
  input logic       line_end,
  input logic       bad_line,
  input logic       last_of_item
);

  // A stalled result transaction stays valid and holds its payload, bad_line aside.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(has_char)
      && $stable(word_end) && $stable(line_end) && $stable(last_of_item))
    else $error("result changed while stalled");

  // The line-end result is always the only result of its input.
  a_line_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_end |-> last_of_item && !has_char)
    else $error("line-end result not final or carries a character");

  // An unclosed quote is only reported on a line end that closes a word.
  a_bad_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_line |-> line_end && word_end)
    else $error("bad_line outside a word-closing line end");

  // A result without a character carries a zero code and is a mark.
  a_no_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_char |-> (out_char == 8'h00) && (word_end || line_end))
    else $error("empty result carries data or no mark");

endmodule

bind quoted_word_line_splitter qwls_checker u_qwls_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_char     (out_char),
  .has_char     (has_char),
  .word_end     (word_end),
  .line_end     (line_end),
  .bad_line     (bad_line),
  .last_of_item (last_of_item)
);
